@@ sv/sahf_pkg.sv @@
// sahf_pkg: shared types, codes and constants for the speech activity hangover block
// no dependencies

package sahf_pkg;

   localparam int unsigned FRAME_MS  = 10;
   localparam int unsigned TIME_W    = 16;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [TIME_W-1:0] TIME_TOP = {TIME_W{1'b1}};

   localparam logic [1:0] MODE_INACTIVE = 2'd0;
   localparam logic [1:0] MODE_RISING   = 2'd1;
   localparam logic [1:0] MODE_ACTIVE   = 2'd2;
   localparam logic [1:0] MODE_FALLING  = 2'd3;

   localparam logic [1:0] EV_NONE       = 2'd0;
   localparam logic [1:0] EV_ACTIVITY   = 2'd1;
   localparam logic [1:0] EV_INACTIVITY = 2'd2;
   localparam logic [1:0] EV_NOINPUT    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEECH_TIME  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE_TIME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOINPUT_TIME = 2'd2;

   localparam logic [TIME_W-1:0] SPEECH_TIME_RST  = 16'd200;
   localparam logic [TIME_W-1:0] SILENCE_TIME_RST = 16'd200;
   localparam logic [TIME_W-1:0] NOINPUT_TIME_RST = 16'd5000;

   typedef struct packed {
      logic [1:0]        mode;
      logic [TIME_W-1:0] elapsed_ms;
   } fsm_state_type;

   typedef struct packed {
      logic [TIME_W-1:0] speech_time_ms;
      logic [TIME_W-1:0] silence_time_ms;
      logic [TIME_W-1:0] noinput_time_ms;
   } thresholds_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [1:0] mode_now;
   } result_type;

endpackage

@@ sv/sahf_step.sv @@
// sahf_step: next-state and event logic for one frame beat
// depends on sahf_pkg

module sahf_step import sahf_pkg::*; (
   input  fsm_state_type  cur,
   input  thresholds_type thr,
   input  logic           kind,
   input  logic           frame_is_audio,
   input  logic           vad_voiced,
   output fsm_state_type  nxt,
   output result_type     res
);

   logic              voiced;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] added;
   logic [1:0]        ev;

   assign voiced = frame_is_audio & vad_voiced;
   assign sum    = {1'b0, cur.elapsed_ms} + (TIME_W+1)'(FRAME_MS);
   assign added  = sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];

   always_comb begin
      nxt = cur;
      ev  = EV_NONE;
      if (kind) begin
         nxt.mode       = MODE_INACTIVE;
         nxt.elapsed_ms = '0;
      end else begin
         case (cur.mode)
            MODE_INACTIVE: begin
               if (voiced) begin
                  nxt.mode       = MODE_RISING;
                  nxt.elapsed_ms = '0;
               end else begin
                  nxt.elapsed_ms = added;
                  if (added >= thr.noinput_time_ms) ev = EV_NOINPUT;
               end
            end
            MODE_RISING: begin
               if (voiced) begin
                  nxt.elapsed_ms = added;
                  if (added >= thr.speech_time_ms) begin
                     ev             = EV_ACTIVITY;
                     nxt.mode       = MODE_ACTIVE;
                     nxt.elapsed_ms = '0;
                  end
               end else begin
                  nxt.mode       = MODE_INACTIVE;
                  nxt.elapsed_ms = '0;
               end
            end
            MODE_ACTIVE: begin
               if (voiced) begin
                  nxt.elapsed_ms = added;
               end else begin
                  nxt.mode       = MODE_FALLING;
                  nxt.elapsed_ms = '0;
               end
            end
            MODE_FALLING: begin
               if (voiced) begin
                  nxt.mode       = MODE_ACTIVE;
                  nxt.elapsed_ms = '0;
               end else begin
                  nxt.elapsed_ms = added;
                  if (added >= thr.silence_time_ms) begin
                     ev             = EV_INACTIVITY;
                     nxt.mode       = MODE_INACTIVE;
                     nxt.elapsed_ms = '0;
                  end
               end
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
      res.event_res = ev;
      res.mode_now  = nxt.mode;
   end

endmodule

@@ sv/speech_activity_hangover_fsm_core.sv @@
// speech_activity_hangover_fsm_core: top level, state and threshold registers, result register
// depends on sahf_pkg and sahf_step
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | kind, frame_is_audio, vad_voiced
//   rsp     | out       | rsp_valid/stall   | event_res, mode_now
//   csr     | in        | csr_wr_en         | csr_index, csr_wr_data
//
// one beat per cycle while req_stall is low; a result appears in the cycle after its request beat
// throughput is set by the single result register: req_stall is high only
// while that register is full and rsp_stall holds it
// reset (synchronous) clears the state and the result valid, and reloads the default thresholds

module speech_activity_hangover_fsm_core import sahf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic                 req_frame_is_audio,
   input  logic                 req_vad_voiced,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_event_res,
   output logic [1:0]           rsp_mode_now,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wr_data
);

   fsm_state_type  state_ff, state_in;
   thresholds_type thr_ff, thr_in;
   result_type     res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_take;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   sahf_step u_step (
      .cur            (state_ff),
      .thr            (thr_ff),
      .kind           (req_kind),
      .frame_is_audio (req_frame_is_audio),
      .vad_voiced     (req_vad_voiced),
      .nxt            (state_in),
      .res            (res_in)
   );

   always_comb begin
      thr_in = thr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SPEECH_TIME:  thr_in.speech_time_ms  = csr_wr_data;
            CSR_SILENCE_TIME: thr_in.silence_time_ms = csr_wr_data;
            CSR_NOINPUT_TIME: thr_in.noinput_time_ms = csr_wr_data;
            default:          thr_in = thr_ff;
         endcase
      end
   end

   assign rsp_valid_in = req_take | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode       <= MODE_INACTIVE;
         state_ff.elapsed_ms <= '0;
         thr_ff.speech_time_ms  <= SPEECH_TIME_RST;
         thr_ff.silence_time_ms <= SILENCE_TIME_RST;
         thr_ff.noinput_time_ms <= NOINPUT_TIME_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) res_ff <= res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = res_ff.event_res;
   assign rsp_mode_now  = res_ff.mode_now;

`ifndef SYNTH
   a_beat_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request beat produced no result");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind |=>
         rsp_mode_now == MODE_INACTIVE && rsp_event_res == EV_NONE
         && state_ff.elapsed_ms == '0)
      else $error("restart beat did not return to inactive");

   a_activity_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_ACTIVITY |-> rsp_mode_now == MODE_ACTIVE)
      else $error("activity event without active mode");

   a_event_clears_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_ACTIVITY || rsp_event_res == EV_INACTIVITY)
         && $past(req_valid && !req_stall) |-> state_ff.elapsed_ms == '0)
      else $error("state change event left elapsed time nonzero");
`endif

endmodule
